>>> rtl/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int HEADER_BYTES = 24;

    localparam int ADDR_W  = 48;
    localparam int LEN_W   = 32;
    localparam int COUNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int STEP_W  = $clog2(2 * MAX_SEGMENTS);

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_INIT  = 2'd2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NOMEM  = 3'd1;
    localparam logic [2:0] ST_BADPTR = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_SMALL  = 3'd4;

    localparam logic REG_HEAP_BASE   = 1'b0;
    localparam logic REG_HEAP_LENGTH = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             free;
        logic [LEN_W-1:0] len;
    } seg_t;

    typedef struct packed {
        logic shift;
        logic compact;
        logic init;
    } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/ffa_if.sv
`default_nettype none
interface ffa_item_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic [ffa_pkg::LEN_W-1:0] request_bytes;
    logic [ffa_pkg::ADDR_W-1:0] release_address;

    modport source (output valid, mode, request_bytes, release_address, input ready);
    modport sink (input valid, mode, request_bytes, release_address, output ready);
endinterface

interface ffa_result_if;
    logic                       valid;
    logic                       ready;
    logic [ffa_pkg::ADDR_W-1:0] payload_address;
    logic [2:0]                 status;

    modport source (output valid, payload_address, status, input ready);
    modport sink (input valid, payload_address, status, output ready);
endinterface
`default_nettype wire

>>> rtl/ffa_cell.sv
`default_nettype none
module ffa_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ffa_pkg::cell_ctl_t ctl,
    input  wire logic              head,
    input  wire logic              prev_valid,
    input  wire ffa_pkg::seg_t     din,
    output ffa_pkg::seg_t          q
);
    logic                      valid_reg;
    logic                      free_reg;
    logic [ffa_pkg::LEN_W-1:0] len_reg;
    logic                      take;

    // compaction: a hole pulls its right neighbor in, a valid entry with a hole
    // on its left moves out
    always_comb
    begin
        take = ctl.shift || (ctl.compact && !valid_reg) || (ctl.init && head);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.init)
        begin
            valid_reg <= head ? din.valid : 1'b0;
        end
        else if (take)
        begin
            valid_reg <= din.valid;
        end
        else if (ctl.compact && !prev_valid)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            free_reg <= din.free;
            len_reg  <= din.len;
        end
    end

    assign q = '{valid: valid_reg, free: free_reg, len: len_reg};
endmodule
`default_nettype wire

>>> rtl/ffa_chain.sv
`default_nettype none
module ffa_chain (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ffa_pkg::cell_ctl_t ctl,
    input  wire ffa_pkg::seg_t     tail,
    input  wire logic              head_sel,
    input  wire ffa_pkg::seg_t     head_seg,
    output ffa_pkg::seg_t [ffa_pkg::MAX_SEGMENTS-1:0] cells
);
    localparam int N = ffa_pkg::MAX_SEGMENTS;

    ffa_pkg::seg_t [N-1:0] din;
    logic          [N-1:0] prev_v;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            din[i]    = (i == N - 1) ? tail : cells[(i + 1) % N];
            prev_v[i] = (i == 0) ? 1'b1 : cells[(i + N - 1) % N].valid;
        end
        if (head_sel)
        begin
            din[0] = head_seg;
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        ffa_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .head       (g == 0),
            .prev_valid (prev_v[g]),
            .din        (din[g]),
            .q          (cells[g])
        );
    end
endmodule
`default_nettype wire

>>> rtl/first_fit_heap_allocator_core.sv
`default_nettype none
// channel   dir  beat payload
// item      in   mode, request_bytes, release_address
// result    out  payload_address, status
// cfg       in   cfg_we, cfg_index, cfg_wdata (plain write, no read-back)
//
// Segment table is a row of MAX_SEGMENTS cells, rotated one entry per cycle.
// Allocate makes one full rotation past the walker. Free runs a mark rotation and,
// if the pointer is found, a merge rotation and a compaction pass.
// One item in flight; the next item is taken once its result is in the output
// register. Result waits there under backpressure. rst_n clears the table.
module first_fit_heap_allocator_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    ffa_item_if.sink                        item,
    ffa_result_if.source                    result,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [ffa_pkg::ADDR_W-1:0] cfg_wdata
);
    localparam int N = ffa_pkg::MAX_SEGMENTS;
    localparam logic [ffa_pkg::LEN_W-1:0]  HDR_L = ffa_pkg::LEN_W'(ffa_pkg::HEADER_BYTES);
    localparam logic [ffa_pkg::ADDR_W-1:0] HDR_A = ffa_pkg::ADDR_W'(ffa_pkg::HEADER_BYTES);
    localparam logic [ffa_pkg::STEP_W-1:0] LAST_ROT = ffa_pkg::STEP_W'(N - 1);
    localparam logic [ffa_pkg::STEP_W-1:0] LAST_CMP = ffa_pkg::STEP_W'(2 * N - 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_ALLOC   = 6'b000010,
        S_MARK    = 6'b000100,
        S_MERGE   = 6'b001000,
        S_COMPACT = 6'b010000,
        S_DONE    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [ffa_pkg::ADDR_W-1:0]  base_reg;
    logic [ffa_pkg::LEN_W-1:0]   length_reg;
    logic [ffa_pkg::ADDR_W-1:0]  start_reg, start_next;
    logic [ffa_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [ffa_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [ffa_pkg::ADDR_W-1:0]  seg_reg, seg_next;
    logic                        done_reg, done_next;
    logic                        split_reg, split_next;
    ffa_pkg::seg_t               buf_reg, buf_next;
    logic [ffa_pkg::LEN_W-1:0]   req_reg;
    logic [ffa_pkg::ADDR_W-1:0]  ptr_reg;
    logic [ffa_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [2:0]                  stat_reg, stat_next;
    logic                        out_v_reg;
    logic [ffa_pkg::ADDR_W-1:0]  out_addr_reg;
    logic [2:0]                  out_stat_reg;

    ffa_pkg::cell_ctl_t                ctl;
    ffa_pkg::seg_t                     tail, head_seg, x, y;
    logic                              head_sel;
    ffa_pkg::seg_t [N-1:0]             cells;

    logic                        accept, load_out;
    logic                        base0, init_ok;
    logic [ffa_pkg::ADDR_W-1:0]  init_start;
    logic [ffa_pkg::LEN_W-1:0]   init_len;
    logic                        hit_exact, hit_split, hit_ptr, can_merge;
    logic [ffa_pkg::LEN_W:0]     need;

    ffa_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .tail     (tail),
        .head_sel (head_sel),
        .head_seg (head_seg),
        .cells    (cells)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign load_out   = (state_reg == S_DONE) && (!out_v_reg || result.ready);

    assign result.valid           = out_v_reg;
    assign result.payload_address = out_addr_reg;
    assign result.status          = out_stat_reg;

    assign x = cells[0];
    assign y = cells[1];

    always_comb
    begin
        base0      = (base_reg == '0);
        init_start = base0 ? ffa_pkg::ADDR_W'(1) : base_reg;
        init_len   = (base0 && length_reg != '0) ? length_reg - 1'b1 : length_reg;
        init_ok    = (init_len >= HDR_L);
        need       = {1'b0, req_reg} + {1'b0, HDR_L};
        hit_exact  = !done_reg && x.valid && x.free && (x.len == req_reg);
        hit_split  = !done_reg && x.valid && x.free && ({1'b0, x.len} > need);
        hit_ptr    = !done_reg && x.valid && ((seg_reg + HDR_A) == ptr_reg);
        can_merge  = x.valid && x.free && y.valid && y.free && (step_reg != LAST_ROT);
    end

    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        count_next = count_reg;
        step_next  = step_reg;
        seg_next   = seg_reg;
        done_next  = done_reg;
        split_next = split_reg;
        buf_next   = buf_reg;
        addr_next  = addr_reg;
        stat_next  = stat_reg;
        ctl        = '0;
        tail       = x;
        head_sel   = 1'b0;
        head_seg   = '{valid: init_ok, free: 1'b1, len: init_len - HDR_L};

        case (state_reg)
            S_IDLE:
            begin
                step_next  = '0;
                seg_next   = start_reg;
                done_next  = 1'b0;
                split_next = 1'b0;
                addr_next  = '0;
                stat_next  = ffa_pkg::ST_OK;
                if (accept)
                begin
                    case (item.mode)
                        ffa_pkg::MODE_ALLOC: state_next = S_ALLOC;
                        ffa_pkg::MODE_FREE:  state_next = S_MARK;
                        ffa_pkg::MODE_INIT:
                        begin
                            ctl.init   = 1'b1;
                            head_sel   = 1'b1;
                            start_next = init_start;
                            count_next = init_ok ? ffa_pkg::COUNT_W'(1) : '0;
                            stat_next  = init_ok ? ffa_pkg::ST_OK : ffa_pkg::ST_SMALL;
                            state_next = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_ALLOC:
            begin
                ctl.shift = 1'b1;
                step_next = step_reg + 1'b1;
                seg_next  = seg_reg + HDR_A + ffa_pkg::ADDR_W'(x.len);
                if (split_reg)
                begin
                    tail     = buf_reg;
                    buf_next = x;
                end
                else if (hit_exact)
                begin
                    tail      = '{valid: 1'b1, free: 1'b0, len: x.len};
                    addr_next = seg_reg + HDR_A;
                    done_next = 1'b1;
                end
                else if (hit_split)
                begin
                    done_next = 1'b1;
                    if (count_reg == ffa_pkg::COUNT_W'(N))
                    begin
                        stat_next = ffa_pkg::ST_FULL;
                    end
                    else
                    begin
                        tail       = '{valid: 1'b1, free: 1'b0, len: req_reg};
                        buf_next   = '{valid: 1'b1, free: 1'b1,
                                       len: ffa_pkg::LEN_W'(need[ffa_pkg::LEN_W:0] == '0) +
                                            x.len - req_reg - HDR_L};
                        split_next = 1'b1;
                        count_next = count_reg + 1'b1;
                        addr_next  = seg_reg + HDR_A;
                    end
                end
                if (step_reg == LAST_ROT)
                begin
                    if (!done_next)
                    begin
                        stat_next = ffa_pkg::ST_NOMEM;
                    end
                    state_next = S_DONE;
                end
            end
            S_MARK:
            begin
                ctl.shift = 1'b1;
                step_next = step_reg + 1'b1;
                seg_next  = seg_reg + HDR_A + ffa_pkg::ADDR_W'(x.len);
                if (hit_ptr)
                begin
                    tail      = '{valid: 1'b1, free: 1'b1, len: x.len};
                    done_next = 1'b1;
                end
                if (step_reg == LAST_ROT)
                begin
                    step_next = '0;
                    if (done_next)
                    begin
                        state_next = S_MERGE;
                    end
                    else
                    begin
                        stat_next  = ffa_pkg::ST_BADPTR;
                        state_next = S_DONE;
                    end
                end
            end
            S_MERGE:
            begin
                ctl.shift = 1'b1;
                step_next = step_reg + 1'b1;
                if (can_merge)
                begin
                    // fold the head into its neighbor, leave a hole behind
                    tail       = '0;
                    head_sel   = 1'b1;
                    head_seg   = '{valid: 1'b1, free: 1'b1, len: x.len + y.len + HDR_L};
                    count_next = count_reg - 1'b1;
                end
                if (step_reg == LAST_ROT)
                begin
                    step_next  = '0;
                    state_next = S_COMPACT;
                end
            end
            S_COMPACT:
            begin
                ctl.compact = 1'b1;
                tail        = '0;
                step_next   = step_reg + 1'b1;
                if (step_reg == LAST_CMP)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            base_reg   <= '0;
            length_reg <= '0;
            start_reg  <= '0;
            count_reg  <= '0;
            step_reg   <= '0;
            done_reg   <= 1'b0;
            split_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
            split_reg <= split_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ffa_pkg::REG_HEAP_BASE:   base_reg   <= cfg_wdata;
                    ffa_pkg::REG_HEAP_LENGTH: length_reg <= cfg_wdata[ffa_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
            if (load_out)
            begin
                out_v_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg  <= seg_next;
        buf_reg  <= buf_next;
        addr_reg <= addr_next;
        stat_reg <= stat_next;
        if (accept)
        begin
            req_reg <= item.request_bytes;
            ptr_reg <= item.release_address;
        end
        if (load_out)
        begin
            out_addr_reg <= addr_reg;
            out_stat_reg <= stat_reg;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ffa_pkg::COUNT_W'(N))
        else $error("segment count above table size");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

    a_merge_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |=> (count_reg <= $past(count_reg)))
        else $error("merge pass grew the table");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMPACT) |-> !item.ready)
        else $error("item taken during compaction");
endmodule
`default_nettype wire
